// ===== rtl/owm_pkg.sv =====
`timescale 1ns / 1ps

package owm_pkg;

   localparam int TICK_W  = 10;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DATA_W = 10;

   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_RESET = 2'd1;
   localparam logic [1:0] KIND_WRITE = 2'd2;
   localparam logic [1:0] KIND_READ  = 2'd3;

   localparam logic [3:0] PH_IDLE     = 4'd0;
   localparam logic [3:0] PH_RST_LOW  = 4'd1;
   localparam logic [3:0] PH_RST_WAIT = 4'd2;
   localparam logic [3:0] PH_RST_TAIL = 4'd3;
   localparam logic [3:0] PH_WR_LOW   = 4'd4;
   localparam logic [3:0] PH_WR_REC   = 4'd5;
   localparam logic [3:0] PH_RD_LOW   = 4'd6;
   localparam logic [3:0] PH_RD_WAIT  = 4'd7;
   localparam logic [3:0] PH_RD_TAIL  = 4'd8;

   localparam logic [CSR_IDX_W-1:0] CSR_RESET_LOW     = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESENCE_WAIT = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESENCE_TAIL = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WRITE_ONE_LOW = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WRITE_ONE_TAIL = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_WRITE_ZERO_LOW = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_READ_SAMPLE  = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_READ_TAIL    = 4'd7;

   localparam logic [9:0] RESET_LOW_INIT      = 10'd480;
   localparam logic [7:0] PRESENCE_WAIT_INIT  = 8'd70;
   localparam logic [7:0] PRESENCE_TAIL_INIT  = 8'd230;
   localparam logic [7:0] WRITE_ONE_LOW_INIT  = 8'd5;
   localparam logic [7:0] WRITE_ONE_TAIL_INIT = 8'd60;
   localparam logic [7:0] WRITE_ZERO_LOW_INIT = 8'd60;
   localparam logic [7:0] READ_SAMPLE_INIT    = 8'd14;
   localparam logic [7:0] READ_TAIL_INIT      = 8'd45;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] tx_byte;
      logic       line_level;
   } req_type;

   typedef struct packed {
      logic       drive_low;
      logic       busy_res;
      logic       done_res;
      logic       presence_fail;
      logic [7:0] rx_byte;
      logic       rejected;
   } rsp_type;

endpackage

// ===== rtl/one_wire_bus_master.sv =====
`timescale 1ns / 1ps

// A result is registered and appears in the cycle after its request transaction is accepted.
// Throughput: one request transaction per clock, sustained while results are taken.
// The output register and bus state advance together, so ready only drops under backpressure.
// Synchronous active-high reset releases the line, returns to idle, sets presence_fail
// and loads the timing registers with their default microsecond counts.
module one_wire_bus_master
   import owm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [9:0]        reset_low_ff;
   logic [7:0]        presence_wait_ff;
   logic [7:0]        presence_tail_ff;
   logic [7:0]        write_one_low_ff;
   logic [7:0]        write_one_tail_ff;
   logic [7:0]        write_zero_low_ff;
   logic [7:0]        read_sample_ff;
   logic [7:0]        read_tail_ff;

   logic [3:0]        phase_ff, phase_in;
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [2:0]        bit_ff, bit_in;
   logic [7:0]        tx_ff, tx_in;
   logic [7:0]        rx_ff, rx_in;
   logic              presence_ff, presence_in;
   logic [7:0]        rx_last_ff, rx_last_in;
   logic              low_ff, low_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              accept;
   logic              done;
   logic              rej;
   logic [7:0]        tx_shifted;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign tx_shifted = {1'b0, tx_ff[7:1]};

   always_comb begin
      phase_in    = phase_ff;
      tick_in     = tick_ff;
      bit_in      = bit_ff;
      tx_in       = tx_ff;
      rx_in       = rx_ff;
      presence_in = presence_ff;
      rx_last_in  = rx_last_ff;
      low_in      = low_ff;
      done        = 1'b0;
      rej         = 1'b0;

      if (req_data.kind != KIND_TICK) begin
         if (phase_ff != PH_IDLE) begin
            rej = 1'b1;
         end else begin
            bit_in = 3'd0;
            low_in = 1'b1;
            unique case (req_data.kind)
               KIND_RESET: begin
                  phase_in = PH_RST_LOW;
                  tick_in  = reset_low_ff;
               end
               KIND_WRITE: begin
                  phase_in = PH_WR_LOW;
                  tx_in    = req_data.tx_byte;
                  tick_in  = {2'b00, req_data.tx_byte[0] ? write_one_low_ff
                                                         : write_zero_low_ff};
               end
               default: begin
                  phase_in = PH_RD_LOW;
                  rx_in    = 8'd0;
                  tick_in  = 10'd1;
               end
            endcase
         end
      end else if (phase_ff != PH_IDLE) begin
         if (tick_ff > 10'd1) begin
            tick_in = tick_ff - 10'd1;
         end else begin
            unique case (phase_ff)
               PH_RST_LOW: begin
                  phase_in = PH_RST_WAIT;
                  tick_in  = {2'b00, presence_wait_ff};
                  low_in   = 1'b0;
               end
               PH_RST_WAIT: begin
                  presence_in = req_data.line_level;
                  phase_in    = PH_RST_TAIL;
                  tick_in     = {2'b00, presence_tail_ff};
                  low_in      = 1'b0;
               end
               PH_WR_LOW: begin
                  phase_in = PH_WR_REC;
                  tick_in  = tx_ff[0] ? {2'b00, write_one_tail_ff} : 10'd1;
                  low_in   = 1'b0;
               end
               PH_WR_REC: begin
                  tx_in = tx_shifted;
                  if (bit_ff == 3'd7) begin
                     done = 1'b1;
                  end else begin
                     bit_in   = bit_ff + 3'd1;
                     phase_in = PH_WR_LOW;
                     tick_in  = {2'b00, tx_shifted[0] ? write_one_low_ff
                                                      : write_zero_low_ff};
                     low_in   = 1'b1;
                  end
               end
               PH_RD_LOW: begin
                  phase_in = PH_RD_WAIT;
                  tick_in  = {2'b00, read_sample_ff};
                  low_in   = 1'b0;
               end
               PH_RD_WAIT: begin
                  rx_in    = {req_data.line_level, rx_ff[7:1]};
                  phase_in = PH_RD_TAIL;
                  tick_in  = {2'b00, read_tail_ff};
                  low_in   = 1'b0;
               end
               PH_RD_TAIL: begin
                  if (bit_ff == 3'd7) begin
                     rx_last_in = rx_ff;
                     done       = 1'b1;
                  end else begin
                     bit_in   = bit_ff + 3'd1;
                     phase_in = PH_RD_LOW;
                     tick_in  = 10'd1;
                     low_in   = 1'b1;
                  end
               end
               default: begin
                  done = 1'b1;
               end
            endcase
            if (done) begin
               phase_in = PH_IDLE;
               tick_in  = 10'd0;
               bit_in   = 3'd0;
               low_in   = 1'b0;
            end
         end
      end

      rsp_in.drive_low     = low_in;
      rsp_in.busy_res      = (phase_in != PH_IDLE);
      rsp_in.done_res      = done;
      rsp_in.presence_fail = presence_in;
      rsp_in.rx_byte       = rx_last_in;
      rsp_in.rejected      = rej;

      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         tick_ff      <= '0;
         bit_ff       <= '0;
         tx_ff        <= '0;
         rx_ff        <= '0;
         presence_ff  <= 1'b1;
         rx_last_ff   <= '0;
         low_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff    <= phase_in;
            tick_ff     <= tick_in;
            bit_ff      <= bit_in;
            tx_ff       <= tx_in;
            rx_ff       <= rx_in;
            presence_ff <= presence_in;
            rx_last_ff  <= rx_last_in;
            low_ff      <= low_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reset_low_ff      <= RESET_LOW_INIT;
         presence_wait_ff  <= PRESENCE_WAIT_INIT;
         presence_tail_ff  <= PRESENCE_TAIL_INIT;
         write_one_low_ff  <= WRITE_ONE_LOW_INIT;
         write_one_tail_ff <= WRITE_ONE_TAIL_INIT;
         write_zero_low_ff <= WRITE_ZERO_LOW_INIT;
         read_sample_ff    <= READ_SAMPLE_INIT;
         read_tail_ff      <= READ_TAIL_INIT;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_RESET_LOW:      reset_low_ff      <= csr_wdata;
            CSR_PRESENCE_WAIT:  presence_wait_ff  <= csr_wdata[7:0];
            CSR_PRESENCE_TAIL:  presence_tail_ff  <= csr_wdata[7:0];
            CSR_WRITE_ONE_LOW:  write_one_low_ff  <= csr_wdata[7:0];
            CSR_WRITE_ONE_TAIL: write_one_tail_ff <= csr_wdata[7:0];
            CSR_WRITE_ZERO_LOW: write_zero_low_ff <= csr_wdata[7:0];
            CSR_READ_SAMPLE:    read_sample_ff    <= csr_wdata[7:0];
            CSR_READ_TAIL:      read_tail_ff      <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

endmodule
